FILE: hw/rtl/kgsca_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// kgsca_pkg
// Shared widths, limits and controller states of the group-by aggregator.
// ============================================================================
package kgsca_pkg;

  // field widths
  localparam int KEY_FIELD_W = 16;
  localparam int GRADE_W     = 9;
  localparam int CNT_W       = 16;
  localparam int SUM_W       = 25;
  localparam int AVG_W       = 9;
  // 2*sum + count fits in 27 bits
  localparam int NUM_W       = 27;

  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 72;

  localparam logic [GRADE_W-1:0] GRADE_CLIP = 9'd400;
  localparam logic [CNT_W-1:0]   COUNT_MAX  = 16'hFFFF;

  localparam int DEF_MAX_GROUPS = 32;
  localparam int DEF_KEY_WIDTH  = 16;

  typedef enum logic [2:0] {
    S_IDLE,    // waiting for a word
    S_UPD,     // read-modify-write of one record
    S_ERD,     // emission: read row
    S_DSTART,  // emission: row data back, start average
    S_DIV,     // emission: average in progress
    S_OUT,     // emission: hand row to output register
    S_EMPTY    // emission: empty-table row
  } state_t;

endpackage

FILE: hw/rtl/kgsca_cam.sv
`timescale 1ns / 1ps
// ============================================================================
// kgsca_cam
// Register CAM of group keys: parallel match over live entries, one write
// port, one registered read port for emission.
// ============================================================================
module kgsca_cam
  import kgsca_pkg::*;
#(
  parameter int MAX_GROUPS = DEF_MAX_GROUPS,
  parameter int KEY_BITS   = DEF_KEY_WIDTH,
  parameter int IDX_W      = 5,
  parameter int USED_W     = 6
) (
  input  logic                clk,
  input  logic [KEY_BITS-1:0] lookup_key,
  input  logic [USED_W-1:0]   used,
  output logic                hit,
  output logic [IDX_W-1:0]    hit_idx,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_idx,
  input  logic [KEY_BITS-1:0] wr_key,
  input  logic [IDX_W-1:0]    rd_idx,
  output logic [KEY_BITS-1:0] rd_key
);

  logic [KEY_BITS-1:0] keys [MAX_GROUPS];

  // keys are unique among live entries, so an OR of matching indexes suffices
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < MAX_GROUPS; i++) begin
      if ((used > USED_W'(i)) && (keys[i] == lookup_key)) begin
        hit     = 1'b1;
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      keys[wr_idx] <= wr_key;
    end
    rd_key <= keys[rd_idx];
  end

endmodule

FILE: hw/rtl/kgsca_store.sv
`timescale 1ns / 1ps
// ============================================================================
// kgsca_store
// Count and sum memory, one write and one registered read per cycle.
// ============================================================================
module kgsca_store
  import kgsca_pkg::*;
#(
  parameter int MAX_GROUPS = DEF_MAX_GROUPS,
  parameter int IDX_W      = 5
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [IDX_W-1:0]       waddr,
  input  logic [CNT_W+SUM_W-1:0] wdata,
  input  logic                   re,
  input  logic [IDX_W-1:0]       raddr,
  output logic [CNT_W+SUM_W-1:0] rdata
);

  logic [CNT_W+SUM_W-1:0] mem [MAX_GROUPS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/kgsca_avg.sv
`timescale 1ns / 1ps
// ============================================================================
// kgsca_avg
// Rounded average (2*sum + count) / (2*count), one quotient bit a cycle.
// ============================================================================
module kgsca_avg
  import kgsca_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] sum,
  input  logic [CNT_W-1:0] cnt,
  output logic             done,
  output logic [AVG_W-1:0] quot
);

  localparam int STEP_W = $clog2(AVG_W);

  logic [NUM_W-1:0]  rem;
  logic [NUM_W-1:0]  dsh;
  logic [AVG_W-1:0]  q;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              zero_den;
  logic              ge;

  assign ge   = (rem >= dsh);
  assign quot = zero_den ? '0 : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (step == STEP_W'(AVG_W - 1))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= (NUM_W'(sum) << 1) + NUM_W'(cnt);
      // 2*count aligned to the top quotient bit
      dsh      <= NUM_W'(cnt) << AVG_W;
      q        <= '0;
      step     <= '0;
      zero_den <= (cnt == '0);
    end else if (busy) begin
      rem  <= ge ? (rem - dsh) : rem;
      q    <= {q[AVG_W-2:0], ge};
      dsh  <= dsh >> 1;
      step <= step + STEP_W'(1);
    end
  end

endmodule

FILE: hw/rtl/keyed_group_sum_count_average.sv
`timescale 1ns / 1ps
// ============================================================================
// keyed_group_sum_count_average
// Group-by aggregator: per-key count, sum and rounded average.
// ============================================================================
// Usage:
//   Input words arrive on the s_axis group. A record word (tuser[0] = 0) with
//   tuser[1] set adds its grade (clipped to 400) to its key's group; a new key
//   takes the next free row, and is dropped when all MAX_GROUPS rows are used.
//   An inactive record is taken and ignored. An end word (tuser[0] = 1) sends
//   one row per group on m_axis in order of first appearance, tlast on the
//   final row, then empties the table; an empty table gives one row with
//   tuser = 0 (no group) and tlast = 1.
//   A record is accepted, then does a read-modify-write of the count/sum
//   memory; an inactive record is only accepted. An end word takes, for
//   each group, a memory read, a 9-step shift-subtract average unit and
//   the output load; the average unit takes the longest of these.
//   s_axis_tready is high only while the controller is idle.
//   m_axis has a single output register; while the receiver stalls, the
//   emission waits at the load step and resumes when the row is taken.
//   Records may be accepted while a finished row still waits on m_axis.
//   Reset (rst, synchronous) empties the table and drops a pending row; row
//   storage itself is not cleared.
// ============================================================================
module keyed_group_sum_count_average
  import kgsca_pkg::*;
#(
  parameter int MAX_GROUPS = DEF_MAX_GROUPS,
  parameter int KEY_WIDTH  = DEF_KEY_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [15:0] group_key, [24:16] grade_hundredths, [31:25] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] func, [1] is_active
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [15:0] out_key, [31:16] member_count, [56:32] value_sum,
  // [65:57] average_hundredths, [71:66] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // [0] row_present
  output logic                   m_axis_tuser,
  // last_row
  output logic                   m_axis_tlast
);

  // keys compare on their low KEY_WIDTH bits, at most the field width
  localparam int KW     = (KEY_WIDTH < KEY_FIELD_W) ? KEY_WIDTH : KEY_FIELD_W;
  localparam int IDX_W  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int USED_W = $clog2(MAX_GROUPS + 1);
  localparam int PAD_W  = OUT_TDATA_W - KEY_FIELD_W - CNT_W - SUM_W - AVG_W;

  state_t state, state_next;

  // input word decode
  logic               in_func;
  logic               in_active;
  logic [KW-1:0]      in_key;
  logic [GRADE_W-1:0] in_grade;
  logic               accept;

  assign in_func   = s_axis_tuser[0];
  assign in_active = s_axis_tuser[1];
  assign in_key    = s_axis_tdata[KW-1:0];
  assign in_grade  = s_axis_tdata[KEY_FIELD_W +: GRADE_W];
  assign accept    = s_axis_tvalid && s_axis_tready;

  // table control
  logic [USED_W-1:0]  used;
  logic [IDX_W-1:0]   emit_idx;
  logic               emit_last;

  // record held between accept and update
  logic               rec_hit;
  logic [IDX_W-1:0]   rec_idx;
  logic [KW-1:0]      rec_key;
  logic [GRADE_W-1:0] rec_grade;

  // CAM
  logic               cam_hit;
  logic [IDX_W-1:0]   cam_hit_idx;
  logic               cam_we;
  logic [KW-1:0]      cam_rd_key;

  // count/sum memory
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic [CNT_W+SUM_W-1:0] mem_wdata;
  logic                   mem_re;
  logic [IDX_W-1:0]       mem_raddr;
  logic [CNT_W+SUM_W-1:0] mem_rdata;
  logic [CNT_W-1:0]       rd_cnt;
  logic [SUM_W-1:0]       rd_sum;

  // average unit
  logic               div_start;
  logic               div_done;
  logic [AVG_W-1:0]   div_quot;

  // row being emitted
  logic [KW-1:0]      row_key;
  logic [CNT_W-1:0]   row_cnt;
  logic [SUM_W-1:0]   row_sum;

  logic               out_free;
  logic               load_row;
  logic               load_empty;
  logic               table_full;

  assign rd_cnt     = mem_rdata[SUM_W +: CNT_W];
  assign rd_sum     = mem_rdata[SUM_W-1:0];
  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign emit_last  = ((USED_W'(emit_idx) + USED_W'(1)) == used);
  assign table_full = (used >= USED_W'(MAX_GROUPS));

  kgsca_cam #(
    .MAX_GROUPS (MAX_GROUPS),
    .KEY_BITS   (KW),
    .IDX_W      (IDX_W),
    .USED_W     (USED_W)
  ) u_cam (
    .clk        (clk),
    .lookup_key (in_key),
    .used       (used),
    .hit        (cam_hit),
    .hit_idx    (cam_hit_idx),
    .wr_en      (cam_we),
    .wr_idx     (used[IDX_W-1:0]),
    .wr_key     (rec_key),
    .rd_idx     (emit_idx),
    .rd_key     (cam_rd_key)
  );

  kgsca_store #(
    .MAX_GROUPS (MAX_GROUPS),
    .IDX_W      (IDX_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  kgsca_avg u_avg (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .sum   (rd_sum),
    .cnt   (rd_cnt),
    .done  (div_done),
    .quot  (div_quot)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_func) begin
            state_next = (used == '0) ? S_EMPTY : S_ERD;
          end else if (in_active) begin
            state_next = S_UPD;
          end
        end
      end
      S_UPD:    state_next = S_IDLE;
      S_ERD:    state_next = S_DSTART;
      S_DSTART: state_next = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = emit_last ? S_IDLE : S_ERD;
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = cam_hit_idx;
    mem_we        = 1'b0;
    mem_waddr     = rec_idx;
    mem_wdata     = {rd_cnt + CNT_W'(1), rd_sum + SUM_W'(rec_grade)};
    cam_we        = 1'b0;
    div_start     = 1'b0;
    load_row      = 1'b0;
    load_empty    = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        mem_re        = accept;
      end
      S_UPD: begin
        if (rec_hit) begin
          // a saturated group drops the record whole
          mem_we = (rd_cnt != COUNT_MAX);
        end else if (!table_full) begin
          mem_we    = 1'b1;
          mem_waddr = used[IDX_W-1:0];
          mem_wdata = {CNT_W'(1), SUM_W'(rec_grade)};
          cam_we    = 1'b1;
        end
      end
      S_ERD: begin
        mem_re    = 1'b1;
        mem_raddr = emit_idx;
      end
      S_DSTART: div_start  = 1'b1;
      S_DIV:    ;
      S_OUT:    load_row   = out_free;
      S_EMPTY:  load_empty = out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      used     <= '0;
      emit_idx <= '0;
    end else begin
      state <= state_next;
      if (cam_we) begin
        used <= used + USED_W'(1);
      end
      if (accept) begin
        emit_idx <= '0;
      end else if (load_row) begin
        if (emit_last) begin
          used <= '0;
        end else begin
          emit_idx <= emit_idx + IDX_W'(1);
        end
      end
    end
  end

  // record and row holding registers
  always_ff @(posedge clk) begin
    if (accept) begin
      rec_hit   <= cam_hit;
      rec_idx   <= cam_hit_idx;
      rec_key   <= in_key;
      rec_grade <= (in_grade > GRADE_CLIP) ? GRADE_CLIP : in_grade;
    end
    if (div_start) begin
      row_key <= cam_rd_key;
      row_cnt <= rd_cnt;
      row_sum <= rd_sum;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_row || load_empty) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_row) begin
      m_axis_tdata <= {PAD_W'(0), div_quot, row_sum, row_cnt, KEY_FIELD_W'(row_key)};
      m_axis_tuser <= 1'b1;
      m_axis_tlast <= emit_last;
    end else if (load_empty) begin
      m_axis_tdata <= '0;
      m_axis_tuser <= 1'b0;
      m_axis_tlast <= 1'b1;
    end
  end

endmodule

FILE: tb/keyed_group_sum_count_average_test.sv
`timescale 1ns / 1ps
// ============================================================================
// keyed_group_sum_count_average_test
// Self-checking bench for the group-by aggregator.
// ============================================================================
// A table of directed words comes first: the empty table, clipped grades,
// skipped records, rounding and words whose ignored fields are set. Random
// data sets follow in four phases of sender and receiver idling. Each set is
// records over a small or a table-overflowing key pool, then an end word. A
// local aggregator predicts every summary row not typed in by hand. Rows
// leaving m_axis are checked in order, field by field.
// ============================================================================
module keyed_group_sum_count_average_test;
  import kgsca_pkg::*;

  localparam int  WATCHDOG_LIMIT = 5000; // cycles with no word moving on either side
  localparam int  HOLD_LEN       = 400;  // long receiver hold-off
  localparam int  SETTLE_CYCLES  = 40;   // settle time after the last owed row
  localparam int  PHASE_ITEMS    = 60;   // minimum counted words per random phase
  localparam int  N_DIRECTED     = 22;
  localparam logic [KEY_FIELD_W-1:0] KEY_MASK =
    KEY_FIELD_W'((64'd1 << DEF_KEY_WIDTH) - 1);

  typedef enum bit {
    FN_RECORD = 1'b0,
    FN_END    = 1'b1
  } func_e;

  // one summary row, as it leaves m_axis
  typedef struct packed {
    logic [KEY_FIELD_W-1:0] grp_key;
    logic [CNT_W-1:0]       members;
    logic [SUM_W-1:0]       total;
    logic [AVG_W-1:0]       avg;
    logic                   present;
    logic                   last;
  } row_t;

  // one input word, plus an optional hand-typed single row for it
  typedef struct packed {
    func_e                  fn;
    logic [KEY_FIELD_W-1:0] key;
    logic [GRADE_W-1:0]     grade;
    logic                   active;
    logic                   typed;
    row_t                   row;
  } stim_word_t;

  localparam row_t EMPTY_ROW = '{16'h0000, 16'd0, 25'd0, 9'd0, 1'b0, 1'b1};
  localparam row_t NO_ROW    = '0;

  // Directed words. Rows typed in only where the answer is obvious; the rest
  // go through the predictor.
  localparam stim_word_t DIRECTED [N_DIRECTED] = '{
    '{FN_END,    16'h0000, 9'd0,   1'b0, 1'b1, EMPTY_ROW}, // empty table after reset
    '{FN_RECORD, 16'h0000, 9'd0,   1'b1, 1'b0, NO_ROW},    // lowest key, zero grade
    '{FN_RECORD, 16'hFFFF, 9'd511, 1'b1, 1'b0, NO_ROW},    // top key, grade clipped
    '{FN_RECORD, 16'hFFFF, 9'd400, 1'b1, 1'b0, NO_ROW},    // exactly at the clip
    '{FN_RECORD, 16'h1234, 9'd401, 1'b0, 1'b0, NO_ROW},    // skipped record
    '{FN_RECORD, 16'h0000, 9'd1,   1'b1, 1'b0, NO_ROW},    // average 0.5 rounds up
    '{FN_RECORD, 16'h0007, 9'd1,   1'b1, 1'b0, NO_ROW},
    '{FN_RECORD, 16'h0007, 9'd2,   1'b1, 1'b0, NO_ROW},    // average 1.5 rounds up
    '{FN_END,    16'h5A5A, 9'd511, 1'b1, 1'b0, NO_ROW},    // end with stray fields set
    '{FN_END,    16'h0000, 9'd0,   1'b0, 1'b1, EMPTY_ROW}, // table was cleared
    '{FN_RECORD, 16'h5555, 9'd200, 1'b0, 1'b0, NO_ROW},    // skipped new key takes no row
    '{FN_END,    16'hFFFF, 9'd0,   1'b0, 1'b1, EMPTY_ROW},
    '{FN_RECORD, 16'hAAAA, 9'h155, 1'b1, 1'b0, NO_ROW},
    '{FN_RECORD, 16'hAAAA, 9'h0AA, 1'b1, 1'b0, NO_ROW},
    '{FN_RECORD, 16'h5555, 9'd0,   1'b1, 1'b0, NO_ROW},
    '{FN_END,    16'h0000, 9'd0,   1'b1, 1'b0, NO_ROW},
    '{FN_RECORD, 16'h00FF, 9'd400, 1'b1, 1'b0, NO_ROW},
    '{FN_END,    16'h0000, 9'd0,   1'b0, 1'b1,
      '{16'h00FF, 16'd1, 25'd400, 9'd400, 1'b1, 1'b1}},
    '{FN_RECORD, 16'hFF00, 9'd511, 1'b1, 1'b0, NO_ROW},
    '{FN_END,    16'h0000, 9'd0,   1'b0, 1'b1,
      '{16'hFF00, 16'd1, 25'd400, 9'd400, 1'b1, 1'b1}},
    '{FN_RECORD, 16'h0001, 9'd1,   1'b1, 1'b0, NO_ROW},
    '{FN_END,    16'h0000, 9'd0,   1'b0, 1'b1,
      '{16'h0001, 16'd1, 25'd1, 9'd1, 1'b1, 1'b1}}
  };

  logic                   clk;
  logic                   rst           = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;

  keyed_group_sum_count_average u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    // [15:0] group_key, [24:16] grade_hundredths, [31:25] zero
    .s_axis_tdata  (s_axis_tdata),
    // [0] func, [1] is_active
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // [15:0] out_key, [31:16] member_count, [56:32] value_sum,
    // [65:57] average_hundredths, [71:66] zero
    .m_axis_tdata  (m_axis_tdata),
    // [0] row_present
    .m_axis_tuser  (m_axis_tuser),
    // last_row
    .m_axis_tlast  (m_axis_tlast)
  );

  // --------------------------------------------------------------------------
  // Aggregator mirror: rows in order of first appearance
  // --------------------------------------------------------------------------
  logic [KEY_FIELD_W-1:0] grp_key_tbl [DEF_MAX_GROUPS];
  logic [CNT_W-1:0]       grp_cnt_tbl [DEF_MAX_GROUPS];
  logic [SUM_W-1:0]       grp_sum_tbl [DEF_MAX_GROUPS];
  int unsigned            groups_held = 0;

  row_t emitted_rows  [$]; // rows caused by the word just taken
  row_t expected_rows [$]; // rows still owed by the block

  int unsigned fail_count    = 0;
  int unsigned items_counted = 0; // words sent in the random part
  int unsigned tx_gap_pct    = 0;
  int unsigned rx_stall_pct  = 0;
  bit          hold_req      = 1'b0;

  function automatic void aggregate_word(input stim_word_t w);
    logic [KEY_FIELD_W-1:0] k;
    logic [GRADE_W-1:0]     g;
    int                     slot;
    row_t                   r;
    longint unsigned        num;
    longint unsigned        den;
    emitted_rows.delete();
    if (w.fn == FN_END) begin
      if (groups_held == 0) begin
        emitted_rows.push_back(EMPTY_ROW);
        return;
      end
      for (int i = 0; i < groups_held; i++) begin
        // round half up: (2*sum + count) / (2*count)
        num       = 64'(grp_sum_tbl[i]) * 2 + 64'(grp_cnt_tbl[i]);
        den       = 64'(grp_cnt_tbl[i]) * 2;
        r.grp_key = grp_key_tbl[i];
        r.members = grp_cnt_tbl[i];
        r.total   = grp_sum_tbl[i];
        r.avg     = AVG_W'(num / den);
        r.present = 1'b1;
        r.last    = (i == groups_held - 1);
        emitted_rows.push_back(r);
      end
      groups_held = 0;
      return;
    end
    if (!w.active) return;
    k    = w.key & KEY_MASK;
    g    = (w.grade > GRADE_CLIP) ? GRADE_CLIP : w.grade;
    slot = -1;
    for (int i = 0; i < groups_held; i++)
      if (grp_key_tbl[i] == k) slot = i;
    if (slot >= 0) begin
      // a saturated group drops the whole record, sum included
      if (grp_cnt_tbl[slot] != COUNT_MAX) begin
        grp_cnt_tbl[slot] = grp_cnt_tbl[slot] + 1'b1;
        grp_sum_tbl[slot] = grp_sum_tbl[slot] + SUM_W'(g);
      end
    end else if (groups_held < DEF_MAX_GROUPS) begin
      grp_key_tbl[groups_held] = k;
      grp_cnt_tbl[groups_held] = 16'd1;
      grp_sum_tbl[groups_held] = SUM_W'(g);
      groups_held++;
    end
    // table full: the new key is simply dropped
  endfunction

  function automatic void note_failure(input string msg, input row_t want, input row_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t ERROR %s: exp key=%h cnt=%0d sum=%0d avg=%0d pres=%b last=%b",
               $realtime, msg, want.grp_key, want.members, want.total, want.avg,
               want.present, want.last,
               " | got key=%h cnt=%0d sum=%0d avg=%0d pres=%b last=%b",
               got.grp_key, got.members, got.total, got.avg, got.present,
               got.last);
  endfunction

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls per phase, plus a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Row checker and watchdog
  // --------------------------------------------------------------------------
  initial begin
    row_t got;
    row_t want;
    int   idle_run;
    idle_run = 0;
    forever begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_run = 0;
      else
        idle_run++;
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        got.grp_key = m_axis_tdata[15:0];
        got.members = m_axis_tdata[31:16];
        got.total   = m_axis_tdata[56:32];
        got.avg     = m_axis_tdata[65:57];
        got.present = m_axis_tuser;
        got.last    = m_axis_tlast;
        if (expected_rows.size() == 0) begin
          note_failure("row with nothing expected", NO_ROW, got);
        end else begin
          want = expected_rows.pop_front();
          if (got.grp_key !== want.grp_key || got.members !== want.members ||
              got.total !== want.total || got.avg !== want.avg ||
              got.present !== want.present || got.last !== want.last)
            note_failure("row mismatch", want, got);
        end
      end
      if (idle_run >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no word moved in %0d cycles, %0d rows outstanding",
                 $realtime, idle_run, expected_rows.size());
        $display("keyed_group_sum_count_average_test: FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  // Offers one word after a random gap and holds it until taken. tvalid is
  // left high on return so back-to-back words need no extra assignment.
  task automatic send_word(input stim_word_t w);
    while ($urandom_range(99) < tx_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, w.grade, w.key};
    s_axis_tuser  <= {w.active, w.fn};
    do @(posedge clk); while (!s_axis_tready);
    aggregate_word(w);
    if (w.typed)
      expected_rows.push_back(w.row);
    else
      foreach (emitted_rows[i]) expected_rows.push_back(emitted_rows[i]);
  endtask

  // Sender pauses until every owed row is back, then lets the block settle.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One data set: records over a pool of distinct keys, then an end word.
  // With fill_first the keys first show up in pool order, so a pool larger
  // than the table overflows it unless skipped records keep keys out.
  task automatic run_data_set(input int unsigned n_keys, input int unsigned n_records,
                              input bit fill_first);
    logic [15:0] pool [64];
    logic [15:0] base;
    logic [15:0] stride;
    stim_word_t  w;
    int unsigned idx;
    base   = 16'($urandom_range(65535));
    stride = 16'($urandom_range(65535)) | 16'h0001; // odd stride keeps keys distinct
    for (int i = 0; i < n_keys; i++) pool[i] = base + 16'(i) * stride;
    for (int r = 0; r < n_records; r++) begin
      idx      = (fill_first && r < n_keys) ? r : $urandom_range(n_keys - 1);
      w.fn     = FN_RECORD;
      w.key    = pool[idx];
      w.grade  = ($urandom_range(3) == 0) ? 9'($urandom_range(511, 401))
                                          : 9'($urandom_range(400));
      w.active = ($urandom_range(99) >= 12);
      w.typed  = 1'b0;
      w.row    = NO_ROW;
      send_word(w);
      items_counted++;
    end
    // stray contents on the end word must be ignored
    w.fn     = FN_END;
    w.key    = 16'($urandom_range(65535));
    w.grade  = 9'($urandom_range(511));
    w.active = 1'($urandom_range(1));
    w.typed  = 1'b0;
    w.row    = NO_ROW;
    send_word(w);
    items_counted++;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned phase_start;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) send_word(DIRECTED[i]);

    // Random phases: none, sender gaps, receiver stalls, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_gap_pct = 49; rx_stall_pct = 0;  end
        2: begin tx_gap_pct = 0;  rx_stall_pct = 49; end
        default: begin tx_gap_pct = 12; rx_stall_pct = 12; end
      endcase
      phase_start = items_counted;
      // First phase: the receiver holds off while this overflowing set and
      // the next one are offered, so emission stalls and tready drops.
      if (ph == 0) hold_req = 1'b1;
      run_data_set(DEF_MAX_GROUPS + 4, DEF_MAX_GROUPS + 12, 1'b1);
      while (items_counted - phase_start < PHASE_ITEMS)
        run_data_set($urandom_range(8, 1), $urandom_range(14), 1'b0);
      wait_drained();
    end

    if (fail_count == 0)
      $display("keyed_group_sum_count_average_test: PASS");
    else
      $display("keyed_group_sum_count_average_test: FAIL");
    $finish;
  end

endmodule
